/* rtl/three_phase_fractional_delay_coupler_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef THREE_PHASE_FRACTIONAL_DELAY_COUPLER_UNIT_MACROS_SVH
`define THREE_PHASE_FRACTIONAL_DELAY_COUPLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TPFDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TPFDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tpfdc_pkg.sv */
// Shared constants, types and helpers of the three-phase delay coupler.
package tpfdc_pkg;

  localparam int SMP_W     = 32;
  localparam int MAX_DEPTH = 64;
  localparam int RING_AW   = $clog2(MAX_DEPTH);
  localparam int LEN_W     = RING_AW + 1;
  localparam int ALPHA_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int MODE_W    = 2;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PHASES    = 3;
  localparam int LANES     = 2 * PHASES;
  localparam int LANE_W    = $clog2(LANES);
  localparam int DIFF_W    = SMP_W + 1;
  localparam int MULB_W    = ALPHA_W + 1;
  localparam int PROD_W    = DIFF_W + MULB_W;
  localparam int NUM_W     = LEN_W + 1;
  localparam int DVD_W     = SMP_W + LEN_W + 1;
  localparam int DIV_CW    = $clog2(DVD_W);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << FRAC_W);

  localparam logic [ACT_W-1:0] ACT_PRELOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PRODUCE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RECORD  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DELAY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd2;

  typedef logic signed [SMP_W-1:0] smp_t;
  // lanes 0..2 voltage a..c, lanes 3..5 current a..c
  typedef logic [LANES-1:0][SMP_W-1:0] row_t;
  typedef logic [PHASES-1:0][SMP_W-1:0] tri_t;

  typedef struct packed {
    logic              preload;
    logic              record;
    logic              start;
    logic              ld_row1;
    logic              ld_row2;
    logic              mul;
    logic              div_ld;
    logic              div_step;
    logic              acc;
    logic              fin;
    logic [LANE_W-1:0] lane;
  } ctl_cmd_t;

  localparam logic signed [PROD_W-1:0] SMAX_W =
    {{(PROD_W-SMP_W+1){1'b0}}, {(SMP_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SMIN_W =
    {{(PROD_W-SMP_W+1){1'b1}}, {(SMP_W-1){1'b0}}};

  function automatic smp_t sat_smp(input logic signed [PROD_W-1:0] v);
    smp_t r;
    if (v > SMAX_W) r = {1'b0, {(SMP_W-1){1'b1}}};
    else if (v < SMIN_W) r = {1'b1, {(SMP_W-1){1'b0}}};
    else r = v[SMP_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/three_phase_fractional_delay_coupler_unit.sv */
// Top level of the three-phase fractional delay coupler.
// Three-phase line coupler with a 64-row delay ring. A beat carries an
// action: preload (fills rings and histories), record (stores the negated
// current and the voltage) or produce (one result beat). A produce first
// fetches two rows, then runs the six lanes (volt a..c, cur a..c) through
// one shared multiplier: a multiply and an accumulate step per lane in
// delay mode, and in linear mode also the bit-serial divider by the ring
// length between them. Hold mode goes straight to the result. The result
// sits in an output register, so the next beat is accepted while it
// waits; a produce that finishes while the previous result is still
// pending waits for it. Config (cfg_we/cfg_idx/cfg_wdata) must be written
// only while idle; the block itself does not enforce it. Ring rows not
// written since the last preload read as the preload value (per-row
// valid bits), so no clearing pass is needed after reset.
module three_phase_fractional_delay_coupler_unit import tpfdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ALPHA_W-1:0]    cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_W-1:0]      in_action,
  input  logic signed [SMP_W-1:0] in_cur_a,
  input  logic signed [SMP_W-1:0] in_cur_b,
  input  logic signed [SMP_W-1:0] in_cur_c,
  input  logic signed [SMP_W-1:0] in_volt_a,
  input  logic signed [SMP_W-1:0] in_volt_b,
  input  logic signed [SMP_W-1:0] in_volt_c,
  input  logic signed [SMP_W-1:0] in_seed_a,
  input  logic signed [SMP_W-1:0] in_seed_b,
  input  logic signed [SMP_W-1:0] in_seed_c,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [SMP_W-1:0] out_volt_a,
  output logic signed [SMP_W-1:0] out_volt_b,
  output logic signed [SMP_W-1:0] out_volt_c,
  output logic signed [SMP_W-1:0] out_cur_a,
  output logic signed [SMP_W-1:0] out_cur_b,
  output logic signed [SMP_W-1:0] out_cur_c
);

  logic [MODE_W-1:0]  mode_r;
  logic [LEN_W-1:0]   len_r;
  logic [ALPHA_W-1:0] alpha_r;
  ctl_cmd_t           cmd;
  row_t               res;
  tri_t               cur, volt, seed;

  // config registers, write-only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_DELAY;
      len_r   <= LEN_W'(1);
      alpha_r <= ALPHA_ONE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE:  mode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_LEN:   len_r   <= cfg_wdata[LEN_W-1:0];
        CFG_ALPHA: alpha_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cur  = {in_cur_c, in_cur_b, in_cur_a};
  assign volt = {in_volt_c, in_volt_b, in_volt_a};
  assign seed = {in_seed_c, in_seed_b, in_seed_a};

  tpfdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .out_ready (out_ready),
    .mode      (mode_r),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tpfdc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .mode      (mode_r),
    .len_raw   (len_r),
    .alpha_raw (alpha_r),
    .in_cur    (cur),
    .in_volt   (volt),
    .in_seed   (seed),
    .res_out   (res)
  );

  assign out_volt_a = res[0];
  assign out_volt_b = res[1];
  assign out_volt_c = res[2];
  assign out_cur_a  = res[3];
  assign out_cur_b  = res[4];
  assign out_cur_c  = res[5];

endmodule

/* rtl/tpfdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tpfdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tpfdc_ctrl.sv */
// Sequencer: decodes beats and steps the datapath lane by lane.
module tpfdc_ctrl import tpfdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [ACT_W-1:0]  in_action,
  input  logic              out_ready,
  input  logic [MODE_W-1:0] mode,
  output logic              in_ready,
  output logic              out_valid,
  output ctl_cmd_t          cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD1  = 8'b0000_0010,
    S_RD2  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_DLD  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_ACC  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LANE_W-1:0]   lane_r, lane_nxt;
  logic [DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                is_delay, is_linear;

  assign is_delay  = (mode == MODE_DELAY);
  assign is_linear = (mode == MODE_LINEAR);

  always_comb begin
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.lane      = lane_r;
    in_ready      = 1'b0;
    if (out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action)
            ACT_PRELOAD: cmd.preload = 1'b1;
            ACT_RECORD:  cmd.record  = 1'b1;
            ACT_PRODUCE: begin
              cmd.start = 1'b1;
              state_nxt = S_RD1;
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        cmd.ld_row1 = 1'b1;
        state_nxt   = S_RD2;
      end
      S_RD2: begin
        cmd.ld_row2 = 1'b1;
        lane_nxt    = '0;
        state_nxt   = (is_delay || is_linear) ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = is_delay ? S_ACC : S_DLD;
      end
      S_DLD: begin
        cmd.div_ld = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DVD_W - 1)) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (lane_r == LANE_W'(LANES - 1)) begin
          state_nxt = S_FIN;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/tpfdc_dp.sv */
// Datapath: ring memory, histories, shared multiplier and divider.
module tpfdc_dp import tpfdc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  input  logic [MODE_W-1:0]  mode,
  input  logic [LEN_W-1:0]   len_raw,
  input  logic [ALPHA_W-1:0] alpha_raw,
  input  tri_t               in_cur,
  input  tri_t               in_volt,
  input  tri_t               in_seed,
  output row_t               res_out
);

  logic [LEN_W-1:0]     len, lm1;
  logic [ALPHA_W-1:0]   alpha_eff;
  logic [RING_AW-1:0]   pos_r, idx, nx, raddr;
  logic                 hpos_r;
  logic [MAX_DEPTH-1:0] vld_r;
  logic                 rvld_r;
  row_t                 fill_r, hist0_r, hist1_r, row1_r, row2_r, res_r, out_r;
  row_t                 rec_row, ring_row, rdata, hist_h, hist_o;
  logic                 wrap, is_delay, is_linear;
  logic [NUM_W-1:0]     num;
  smp_t                 c1, c2;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r, prod_mag, rnd, sum_d, sum_l, q_s;
  logic                 neg_r;
  logic [DVD_W-1:0]     dvq_r;
  logic [LEN_W-1:0]     rem_r, trial;
  logic                 ge;

  assign is_delay  = (mode == MODE_DELAY);
  assign is_linear = (mode == MODE_LINEAR);

  // length clamp: zero acts as one, beyond depth acts as depth
  always_comb begin
    if (len_raw == '0) len = LEN_W'(1);
    else if (len_raw > LEN_W'(MAX_DEPTH)) len = LEN_W'(MAX_DEPTH);
    else len = len_raw;
  end
  assign lm1       = len - 1'b1;
  assign alpha_eff = (alpha_raw > ALPHA_ONE) ? ALPHA_ONE : alpha_raw;
  assign idx       = (LEN_W'(pos_r) < len) ? pos_r : lm1[RING_AW-1:0];
  assign nx        = (LEN_W'(idx) == lm1) ? '0 : idx + 1'b1;
  assign num       = NUM_W'(len) + NUM_W'(idx) + NUM_W'(1);
  assign wrap      = (LEN_W'(pos_r) + LEN_W'(1)) >= len;

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      rec_row[p]          = in_volt[p];
      rec_row[PHASES + p] = sat_smp(-PROD_W'(signed'(in_cur[p])));
    end
  end

  assign raddr = cmd.start ? idx : nx;

  tpfdc_ram #(.WIDTH(LANES * SMP_W), .DEPTH(MAX_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.record),
    .waddr (pos_r),
    .wdata (rec_row),
    .re    (cmd.start | cmd.ld_row1),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rows never written since preload read as the preload value
  assign ring_row = rvld_r ? rdata : fill_r;
  assign hist_h   = hpos_r ? hist1_r : hist0_r;
  assign hist_o   = hpos_r ? hist0_r : hist1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      hpos_r  <= 1'b0;
      vld_r   <= '0;
      rvld_r  <= 1'b0;
      fill_r  <= '0;
      hist0_r <= '0;
      hist1_r <= '0;
    end else begin
      if (cmd.start | cmd.ld_row1) rvld_r <= vld_r[raddr];
      if (cmd.preload) begin
        vld_r  <= '0;
        pos_r  <= '0;
        hpos_r <= 1'b0;
        for (int p = 0; p < PHASES; p++) begin
          fill_r[p]           <= in_volt[p];
          fill_r[PHASES + p]  <= in_cur[p];
          hist0_r[p]          <= in_volt[p];
          hist0_r[PHASES + p] <= in_seed[p];
          hist1_r[p]          <= in_volt[p];
          hist1_r[PHASES + p] <= in_cur[p];
        end
      end else if (cmd.record) begin
        vld_r[pos_r] <= 1'b1;
        if (wrap) begin
          pos_r <= '0;
          if (hpos_r) hist1_r <= rec_row;
          else hist0_r <= rec_row;
          hpos_r <= is_linear ? ~hpos_r : 1'b0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  // lane operands; delay uses c1-c2 by alpha, linear uses c2-c1 by num
  assign c1    = row1_r[cmd.lane];
  assign c2    = row2_r[cmd.lane];
  assign mul_a = is_delay ? (DIFF_W'(c1) - DIFF_W'(c2)) : (DIFF_W'(c2) - DIFF_W'(c1));
  assign mul_b = is_delay ? signed'({1'b0, alpha_eff}) : signed'(MULB_W'(num));

  assign prod_mag = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign trial    = {rem_r[LEN_W-2:0], dvq_r[DVD_W-1]};
  assign ge       = (trial >= len);

  assign rnd   = (prod_r + PROD_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
  assign sum_d = PROD_W'(c2) + rnd;
  assign q_s   = neg_r ? -signed'(PROD_W'(dvq_r)) : signed'(PROD_W'(dvq_r));
  assign sum_l = PROD_W'(c1) + q_s;

  always_ff @(posedge clk) begin
    if (cmd.ld_row1) row1_r <= is_delay ? ring_row : hist_h;
    if (cmd.ld_row2) row2_r <= is_delay ? ring_row : hist_o;
    if (cmd.mul) prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd.div_ld) begin
      neg_r <= prod_r[PROD_W-1];
      dvq_r <= DVD_W'(prod_mag) + DVD_W'(len >> 1);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? (trial - len) : trial;
      dvq_r <= {dvq_r[DVD_W-2:0], ge};
    end
    if (cmd.acc) res_r[cmd.lane] <= is_delay ? sat_smp(sum_d) : sat_smp(sum_l);
    if (cmd.fin) out_r <= (is_delay || is_linear) ? res_r : row1_r;
  end

  assign res_out = out_r;

endmodule

/* rtl/tpfdc_checker.sv */
// Port-level checker for the coupler, bound to the top level.
`include "three_phase_fractional_delay_coupler_unit_macros.svh"

module tpfdc_checker import tpfdc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [ACT_W-1:0] in_action,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SMP_W-1:0] out_volt_a,
  input logic [SMP_W-1:0] out_cur_c
);

  `TPFDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `TPFDC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_volt_a) && $stable(out_cur_c), "result changed while stalled")
  `TPFDC_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && in_action != ACT_PRODUCE && !out_valid, !out_valid, "result without produce")
  `TPFDC_ASSERT_NEXT(a_busy, in_valid && in_ready && in_action == ACT_PRODUCE, !in_ready, "beat taken during produce")

endmodule

bind three_phase_fractional_delay_coupler_unit tpfdc_checker u_tpfdc_checker (.*);
